@@ sv/spi_clock_divider_search_unit_defines.svh @@
// Assertion macros shared by the clock divider search unit.
`ifndef SPI_CLOCK_DIVIDER_SEARCH_UNIT_DEFINES_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define SPICDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spicds: implication check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define SPICDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spicds: next-cycle check failed");

`endif

@@ sv/spicds_pkg.sv @@
// Types and constants for the clock divider search unit.
`default_nettype none

package spicds_pkg;

    localparam logic [7:0]  PRESCALE_MIN  = 8'd2;
    localparam logic [7:0]  PRESCALE_MAX  = 8'd254;
    localparam logic [7:0]  PRESCALE_STEP = 8'd2;
    localparam logic [7:0]  FACTOR_M1_MAX = 8'd255;
    // largest allowed clock / target ratio plus one (254 * 255 + 1)
    localparam logic [16:0] RATIO_LIMIT   = 17'd64771;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DIVIDE,
        ST_FAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_target;
        logic init_scan;
        logic adv_f;
        logic adv_p;
        logic take_best;
        logic write_ok;
        logic write_bad;
    } cmd_t;

    typedef struct packed {
        logic bad_req;
        logic qual;
        logic improve;
        logic last_f;
        logic last_p;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ sv/spicds_div.sv @@
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 16-bit divisor.
`default_nettype none

module spicds_div
    import spicds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [16:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dsr_next    = dsr_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = 5'd31;
            rem_next    = '0;
            quo_next    = dividend;
            dsr_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next = fits ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
            quo_next = {quo_reg[30:0], fits};
            if (cnt_reg == 5'd0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ sv/spicds_dp.sv @@
// Datapath: clock register, pair scan counters, qualify/improve tests, best pair, result.
`default_nettype none

module spicds_dp
    import spicds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic [31:0] target_hz,
    input  wire logic        out_ready,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic             out_valid,
    output logic             ok,
    output logic [7:0]       prescale,
    output logic [7:0]       rate_minus_one
);

    logic [31:0] clock_hz_reg, clock_hz_next;
    logic [31:0] target_reg, target_next;
    logic [32:0] tp1_reg, tp1_next;
    logic [7:0]  pre_reg, pre_next;
    logic [7:0]  fm1_reg, fm1_next;
    logic [15:0] d_reg, d_next;
    // best generated clock plus one; zero means nothing found yet
    logic [32:0] gp1_reg, gp1_next;
    logic [7:0]  best_pre_reg, best_pre_next;
    logic [7:0]  best_fm1_reg, best_fm1_next;
    logic        out_valid_reg, out_valid_next;
    logic        ok_reg, ok_next;
    logic [7:0]  prescale_reg, prescale_next;
    logic [7:0]  rate_reg, rate_next;

    logic [48:0] lim_prod;
    logic [48:0] qual_prod;
    logic [48:0] imp_prod;
    logic [48:0] clock_ext;
    logic [7:0]  pre_inc;
    logic        div_done;
    logic [31:0] div_quo;

    spicds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.take_best),
        .dividend (clock_hz_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign clock_ext = {17'd0, clock_hz_reg};
    assign lim_prod  = 49'(target_reg) * 49'(RATIO_LIMIT);
    // generated clock <= target  <=>  clock < (target + 1) * d
    assign qual_prod = 49'(tp1_reg) * 49'(d_reg);
    // generated clock > best     <=>  clock >= (best + 1) * d
    assign imp_prod  = 49'(gp1_reg) * 49'(d_reg);
    assign pre_inc   = pre_reg + PRESCALE_STEP;

    always_comb
    begin
        status.bad_req  = (clock_hz_reg == 32'd0) || (target_reg == 32'd0)
                          || ({1'b0, clock_hz_reg} < {target_reg, 1'b0})
                          || (clock_ext >= lim_prod);
        status.qual     = clock_ext < qual_prod;
        status.improve  = imp_prod <= clock_ext;
        status.last_f   = fm1_reg == FACTOR_M1_MAX;
        status.last_p   = pre_reg == PRESCALE_MAX;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        clock_hz_next  = cfg_wr_en ? cfg_wr_data : clock_hz_reg;
        target_next    = target_reg;
        tp1_next       = tp1_reg;
        pre_next       = pre_reg;
        fm1_next       = fm1_reg;
        d_next         = d_reg;
        gp1_next       = gp1_reg;
        best_pre_next  = best_pre_reg;
        best_fm1_next  = best_fm1_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        prescale_next  = prescale_reg;
        rate_next      = rate_reg;

        if (cmd.load_target)
        begin
            target_next = target_hz;
            tp1_next    = {1'b0, target_hz} + 33'd1;
        end
        if (cmd.init_scan)
        begin
            pre_next      = PRESCALE_MIN;
            fm1_next      = '0;
            d_next        = {8'd0, PRESCALE_MIN};
            gp1_next      = '0;
            best_pre_next = PRESCALE_MIN;
            best_fm1_next = '0;
        end
        if (cmd.adv_f)
        begin
            fm1_next = fm1_reg + 8'd1;
            d_next   = d_reg + {8'd0, pre_reg};
        end
        if (cmd.adv_p)
        begin
            pre_next = pre_inc;
            fm1_next = '0;
            d_next   = {8'd0, pre_inc};
        end
        if (cmd.take_best)
        begin
            best_pre_next = pre_reg;
            best_fm1_next = fm1_reg;
        end
        if (div_done)
        begin
            gp1_next = {1'b0, div_quo} + 33'd1;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.write_ok)
        begin
            out_valid_next = 1'b1;
            ok_next        = 1'b1;
            prescale_next  = best_pre_reg;
            rate_next      = best_fm1_reg;
        end
        else if (cmd.write_bad)
        begin
            out_valid_next = 1'b1;
            ok_next        = 1'b0;
            prescale_next  = '0;
            rate_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clock_hz_reg  <= clock_hz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        tp1_reg      <= tp1_next;
        pre_reg      <= pre_next;
        fm1_reg      <= fm1_next;
        d_reg        <= d_next;
        gp1_reg      <= gp1_next;
        best_pre_reg <= best_pre_next;
        best_fm1_reg <= best_fm1_next;
        ok_reg       <= ok_next;
        prescale_reg <= prescale_next;
        rate_reg     <= rate_next;
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign prescale       = prescale_reg;
    assign rate_minus_one = rate_reg;

endmodule

`default_nettype wire

@@ sv/spicds_ctrl.sv @@
// Controller state machine: request check, pair scan, divide on improvement, result write.
`default_nettype none

module spicds_ctrl
    import spicds_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   scan_end;

    // past the first qualifying factor nothing in this prescaler can do better
    assign scan_end = status.qual || status.last_f;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.bad_req ? ST_FAIL : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.qual && status.improve)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (scan_end && status.last_p)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = status.last_p ? ST_DONE : ST_SCAN;
                end
            end
            ST_FAIL, ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.load_target = in_valid;
            end
            ST_CHECK:
            begin
                cmd.init_scan = !status.bad_req;
            end
            ST_SCAN:
            begin
                priority if (status.qual && status.improve)
                begin
                    cmd.take_best = 1'b1;
                end
                else if (scan_end)
                begin
                    cmd.adv_p = !status.last_p;
                end
                else
                begin
                    cmd.adv_f = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                cmd.adv_p = status.div_done && !status.last_p;
            end
            ST_FAIL:
            begin
                cmd.write_bad = status.out_free;
            end
            ST_DONE:
            begin
                cmd.write_ok = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/spi_clock_divider_search_unit.sv @@
// Top level of the serial clock prescaler/rate search unit.
// Invalid request: after the check and fail states, the result is registered once the output register is free.
// Valid request: the pairs are tested in turn, stopping each prescaler at its first qualifying
// factor, and each improvement waits for the 32-step divider before the scan goes on.
// One item in flight; the next is taken while the last result waits in the output register.
// Reset (rst_n, async low) clears the clock register to 0, the controller and output valid.
`default_nettype none
`include "spi_clock_divider_search_unit_defines.svh"

module spi_clock_divider_search_unit
    import spicds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] target_hz,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [7:0]       prescale,
    output logic [7:0]       rate_minus_one
);

    cmd_t    cmd;
    status_t status;

    spicds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    spicds_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .target_hz      (target_hz),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .ok             (ok),
        .prescale       (prescale),
        .rate_minus_one (rate_minus_one)
    );

    `SPICDS_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
    `SPICDS_ASSERT_IMP(a_fail_zeroes, out_valid && !ok, prescale == 8'd0 && rate_minus_one == 8'd0)
    `SPICDS_ASSERT_IMP(a_prescale_even, out_valid && ok, prescale >= PRESCALE_MIN && !prescale[0])

endmodule

`default_nettype wire
